FILE: rtl/hid_to_ps2_set2_scan_fifo_assert.svh
// Assertion macros for the HID to PS/2 scan FIFO block.
// Included by h2ps2_datapath, the RTL file that carries concurrent assertions; no dependencies.
`ifndef HID_TO_PS2_SET2_SCAN_FIFO_ASSERT_SVH
`define HID_TO_PS2_SET2_SCAN_FIFO_ASSERT_SVH

// same-cycle implication
`define H2PS2_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define H2PS2_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/h2ps2_pkg.sv
// Shared types, constants and the HID usage to set 2 make code table.
// No dependencies; used by the datapath, controller and top level RTL files.
`default_nettype none

package h2ps2_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 512;

   localparam logic [7:0] PFX_EXT = 8'hE0;
   localparam logic [7:0] PFX_BRK = 8'hF0;

   // which byte a push writes
   localparam logic [1:0] SEL_EXT  = 2'd0;
   localparam logic [1:0] SEL_BRK  = 2'd1;
   localparam logic [1:0] SEL_CODE = 2'd2;

   // bit 8: extended (E0 prefix), bits 7..0: make code, 0 = unmapped
   typedef logic [8:0] keymap_entry_type;

   typedef struct packed {
      logic       load;       // latch request word, clear result
      logic       set_empty;  // read found the FIFO empty
      logic       do_read;    // read memory at read pointer, pop
      logic       take_read;  // move read data into result
      logic       push;       // write one byte (dropped when full)
      logic [1:0] sel;        // byte select for push
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic mapped;
      logic ext;
      logic pressed;
      logic empty;
   } dp_status_type;

   function automatic keymap_entry_type keymap(input logic [7:0] usage);
      keymap_entry_type entry;
      case (usage)
         8'h04: entry = {1'b0, 8'h1C};
         8'h05: entry = {1'b0, 8'h32};
         8'h06: entry = {1'b0, 8'h21};
         8'h07: entry = {1'b0, 8'h23};
         8'h08: entry = {1'b0, 8'h24};
         8'h09: entry = {1'b0, 8'h2B};
         8'h0A: entry = {1'b0, 8'h34};
         8'h0B: entry = {1'b0, 8'h33};
         8'h0C: entry = {1'b0, 8'h43};
         8'h0D: entry = {1'b0, 8'h3B};
         8'h0E: entry = {1'b0, 8'h42};
         8'h0F: entry = {1'b0, 8'h4B};
         8'h10: entry = {1'b0, 8'h3A};
         8'h11: entry = {1'b0, 8'h31};
         8'h12: entry = {1'b0, 8'h44};
         8'h13: entry = {1'b0, 8'h4D};
         8'h14: entry = {1'b0, 8'h15};
         8'h15: entry = {1'b0, 8'h2D};
         8'h16: entry = {1'b0, 8'h1B};
         8'h17: entry = {1'b0, 8'h2C};
         8'h18: entry = {1'b0, 8'h3C};
         8'h19: entry = {1'b0, 8'h2A};
         8'h1A: entry = {1'b0, 8'h1D};
         8'h1B: entry = {1'b0, 8'h22};
         8'h1C: entry = {1'b0, 8'h35};
         8'h1D: entry = {1'b0, 8'h1A};
         8'h1E: entry = {1'b0, 8'h16};
         8'h1F: entry = {1'b0, 8'h1E};
         8'h20: entry = {1'b0, 8'h26};
         8'h21: entry = {1'b0, 8'h25};
         8'h22: entry = {1'b0, 8'h2E};
         8'h23: entry = {1'b0, 8'h36};
         8'h24: entry = {1'b0, 8'h3D};
         8'h25: entry = {1'b0, 8'h3E};
         8'h26: entry = {1'b0, 8'h46};
         8'h27: entry = {1'b0, 8'h45};
         8'h28: entry = {1'b0, 8'h5A};
         8'h29: entry = {1'b0, 8'h76};
         8'h2A: entry = {1'b0, 8'h66};
         8'h2B: entry = {1'b0, 8'h0D};
         8'h2C: entry = {1'b0, 8'h29};
         8'h2D: entry = {1'b0, 8'h4E};
         8'h2E: entry = {1'b0, 8'h55};
         8'h2F: entry = {1'b0, 8'h54};
         8'h30: entry = {1'b0, 8'h5B};
         8'h31: entry = {1'b0, 8'h5D};
         8'h32: entry = {1'b0, 8'h5D};
         8'h33: entry = {1'b0, 8'h4C};
         8'h34: entry = {1'b0, 8'h52};
         8'h35: entry = {1'b0, 8'h0E};
         8'h36: entry = {1'b0, 8'h41};
         8'h37: entry = {1'b0, 8'h49};
         8'h38: entry = {1'b0, 8'h4A};
         8'h39: entry = {1'b0, 8'h58};
         8'h3A: entry = {1'b0, 8'h05};
         8'h3B: entry = {1'b0, 8'h06};
         8'h3C: entry = {1'b0, 8'h04};
         8'h3D: entry = {1'b0, 8'h0C};
         8'h3E: entry = {1'b0, 8'h03};
         8'h3F: entry = {1'b0, 8'h0B};
         8'h40: entry = {1'b0, 8'h83};
         8'h41: entry = {1'b0, 8'h0A};
         8'h42: entry = {1'b0, 8'h01};
         8'h43: entry = {1'b0, 8'h09};
         8'h44: entry = {1'b0, 8'h78};
         8'h45: entry = {1'b0, 8'h07};
         8'h47: entry = {1'b0, 8'h7E};
         8'h49: entry = {1'b1, 8'h70};
         8'h4A: entry = {1'b1, 8'h6C};
         8'h4B: entry = {1'b1, 8'h7D};
         8'h4C: entry = {1'b1, 8'h71};
         8'h4D: entry = {1'b1, 8'h69};
         8'h4E: entry = {1'b1, 8'h7A};
         8'h4F: entry = {1'b1, 8'h74};
         8'h50: entry = {1'b1, 8'h6B};
         8'h51: entry = {1'b1, 8'h72};
         8'h52: entry = {1'b1, 8'h75};
         8'h53: entry = {1'b0, 8'h77};
         8'h54: entry = {1'b1, 8'h4A};
         8'h55: entry = {1'b0, 8'h7C};
         8'h56: entry = {1'b0, 8'h7B};
         8'h57: entry = {1'b0, 8'h79};
         8'h58: entry = {1'b1, 8'h5A};
         8'h59: entry = {1'b0, 8'h69};
         8'h5A: entry = {1'b0, 8'h72};
         8'h5B: entry = {1'b0, 8'h7A};
         8'h5C: entry = {1'b0, 8'h6B};
         8'h5D: entry = {1'b0, 8'h73};
         8'h5E: entry = {1'b0, 8'h74};
         8'h5F: entry = {1'b0, 8'h6C};
         8'h60: entry = {1'b0, 8'h75};
         8'h61: entry = {1'b0, 8'h7D};
         8'h62: entry = {1'b0, 8'h70};
         8'h63: entry = {1'b0, 8'h71};
         8'h64: entry = {1'b0, 8'h61};
         8'h65: entry = {1'b1, 8'h2F};
         8'hE0: entry = {1'b0, 8'h14};
         8'hE1: entry = {1'b0, 8'h12};
         8'hE2: entry = {1'b0, 8'h11};
         8'hE3: entry = {1'b1, 8'h1F};
         8'hE4: entry = {1'b1, 8'h14};
         8'hE5: entry = {1'b0, 8'h59};
         8'hE6: entry = {1'b1, 8'h11};
         8'hE7: entry = {1'b1, 8'h27};
         default: entry = 9'h000;
      endcase
      return entry;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/h2ps2_chan_if.sv
// Valid/ready channel interfaces for request and response words.
// No dependencies.
`default_nettype none

interface h2ps2_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] usage_id;
   logic       pressed;

   modport source (output valid, action, usage_id, pressed, input ready);
   modport sink   (input valid, action, usage_id, pressed, output ready);
endinterface

interface h2ps2_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_byte;
   logic       queue_empty;
   logic [1:0] bytes_queued;
   logic       dropped;

   modport source (output valid, scan_byte, queue_empty, bytes_queued, dropped,
                   input ready);
   modport sink   (input valid, scan_byte, queue_empty, bytes_queued, dropped,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/h2ps2_datapath.sv
// Datapath: request latch, keymap lookup, scan byte FIFO memory, result regs.
// Depends on h2ps2_pkg and the assertion macro header.
`default_nettype none
`include "hid_to_ps2_set2_scan_fifo_assert.svh"

module h2ps2_datapath #(
   parameter int FIFO_DEPTH = h2ps2_pkg::DEFAULT_FIFO_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_action,
   input  wire logic [7:0]             req_usage_id,
   input  wire logic                   req_pressed,
   input  wire h2ps2_pkg::ctrl_cmd_type cmd,
   output h2ps2_pkg::dp_status_type    status,
   output logic [7:0]                  rsp_scan_byte,
   output logic                        rsp_queue_empty,
   output logic [1:0]                  rsp_bytes_queued,
   output logic                        rsp_dropped
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [7:0] mem [FIFO_DEPTH];

   logic                        action_ff;
   logic [7:0]                  usage_ff;
   logic                        down_ff;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [7:0]                  rd_data_ff;
   logic [7:0]                  byte_ff;
   logic                        empty_ff;
   logic [1:0]                  stored_ff;
   logic                        lost_ff;
   h2ps2_pkg::keymap_entry_type entry;
   logic                        full;
   logic                        empty;
   logic                        mem_we;
   logic [PTR_W-1:0]            mem_addr;
   logic [7:0]                  push_byte;

   assign entry = h2ps2_pkg::keymap(usage_ff);
   assign full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);

   assign status = '{is_read: action_ff,
                     mapped:  (entry[7:0] != 8'h00),
                     ext:     entry[8],
                     pressed: down_ff,
                     empty:   empty};

   always_comb begin
      case (cmd.sel)
         h2ps2_pkg::SEL_EXT: push_byte = h2ps2_pkg::PFX_EXT;
         h2ps2_pkg::SEL_BRK: push_byte = h2ps2_pkg::PFX_BRK;
         default:            push_byte = entry[7:0];
      endcase
   end

   assign mem_we   = cmd.push && !full;
   assign mem_addr = cmd.do_read ? rd_ptr_ff : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (mem_we) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (cmd.do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // single-port memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= push_byte;
      end
      if (cmd.do_read) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         usage_ff  <= req_usage_id;
         down_ff   <= req_pressed;
         byte_ff   <= 8'h00;
         empty_ff  <= 1'b0;
         stored_ff <= 2'd0;
         lost_ff   <= 1'b0;
      end else begin
         if (cmd.set_empty) begin
            empty_ff <= 1'b1;
         end
         if (cmd.take_read) begin
            byte_ff <= rd_data_ff;
         end
         if (cmd.push) begin
            if (full) begin
               lost_ff <= 1'b1;
            end else begin
               stored_ff <= stored_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_scan_byte    = byte_ff;
   assign rsp_queue_empty  = empty_ff;
   assign rsp_bytes_queued = stored_ff;
   assign rsp_dropped      = lost_ff;

   `H2PS2_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(FIFO_DEPTH), "fill count above depth")
   `H2PS2_ASSERT_NEXT(a_full_push_holds, clock, reset, cmd.push && full,
      $stable(count_ff) && $stable(wr_ptr_ff), "push into full FIFO changed state")
   `H2PS2_ASSERT_NEXT(a_pop_decrements, clock, reset, cmd.do_read,
      count_ff == CNT_W'($past(count_ff) - 1'b1), "pop did not drop fill count")
   `H2PS2_ASSERT_IMPLY(a_ptr_match, clock, reset,
      count_ff == '0 || count_ff == CNT_W'(FIFO_DEPTH),
      wr_ptr_ff == rd_ptr_ff, "pointers disagree with fill count")

endmodule

`default_nettype wire

FILE: rtl/h2ps2_ctrl.sv
// Controller FSM: sequences decode, pops and up to three pushes per word.
// Depends on h2ps2_pkg.
`default_nettype none

module h2ps2_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire h2ps2_pkg::dp_status_type status,
   output h2ps2_pkg::ctrl_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RDATA  = 3'd2;
   localparam logic [2:0] S_EXT    = 3'd3;
   localparam logic [2:0] S_BRK    = 3'd4;
   localparam logic [2:0] S_CODE   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = h2ps2_pkg::SEL_CODE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_read) begin
               if (status.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.do_read = 1'b1;
                  state_in    = S_RDATA;
               end
            end else if (!status.mapped) begin
               state_in = S_RESP;
            end else if (status.ext) begin
               state_in = S_EXT;
            end else if (!status.pressed) begin
               state_in = S_BRK;
            end else begin
               state_in = S_CODE;
            end
         end
         S_RDATA: begin
            cmd.take_read = 1'b1;
            state_in      = S_RESP;
         end
         S_EXT: begin
            cmd.push = 1'b1;
            cmd.sel  = h2ps2_pkg::SEL_EXT;
            state_in = status.pressed ? S_CODE : S_BRK;
         end
         S_BRK: begin
            cmd.push = 1'b1;
            cmd.sel  = h2ps2_pkg::SEL_BRK;
            state_in = S_CODE;
         end
         S_CODE: begin
            cmd.push = 1'b1;
            cmd.sel  = h2ps2_pkg::SEL_CODE;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hid_to_ps2_set2_scan_fifo.sv
// Top level of the USB HID to PS/2 set 2 scan code translator with byte FIFO.
// Depends on h2ps2_pkg, h2ps2_chan_if, h2ps2_ctrl and h2ps2_datapath.
//
// Each request word is either a key event (action 0: HID usage ID plus a
// pressed flag) or a pop (action 1), and yields exactly one response word.
// A mapped key queues E0 for extended keys, F0 on release, then the make
// code; unmapped usages queue nothing. A byte that meets a full FIFO is
// discarded and the rest of the sequence still tried, so dropped flags a
// cut-short sequence and bytes_queued tells how many bytes landed. A pop
// returns the oldest byte, or queue_empty with a zero byte. The block takes
// one word at a time: the FSM passes through a decode state, then a push
// state for each byte written (the FIFO memory has a single port), or a
// read-data state for the registered memory read on a pop, then holds the
// response until taken. The next request is taken the cycle after the
// response handshake. No clearing pass: FIFO entries are only read after
// written.
`default_nettype none

module hid_to_ps2_set2_scan_fifo #(
   parameter int FIFO_DEPTH = h2ps2_pkg::DEFAULT_FIFO_DEPTH  // 4 .. 4096 bytes
) (
   input wire logic   clock,
   input wire logic   reset,
   h2ps2_req_if.sink  req_chan,
   h2ps2_rsp_if.source rsp_chan
);

   h2ps2_pkg::ctrl_cmd_type  cmd;
   h2ps2_pkg::dp_status_type status;

   // sequencer: one word in flight
   h2ps2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // FIFO memory, pointers, lookup and response registers
   h2ps2_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_chan.action),
      .req_usage_id     (req_chan.usage_id),
      .req_pressed      (req_chan.pressed),
      .cmd              (cmd),
      .status           (status),
      .rsp_scan_byte    (rsp_chan.scan_byte),
      .rsp_queue_empty  (rsp_chan.queue_empty),
      .rsp_bytes_queued (rsp_chan.bytes_queued),
      .rsp_dropped      (rsp_chan.dropped)
   );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for hid_to_ps2_set2_scan_fifo: HID key events and pops in, one response word out.
// Depends on h2ps2_pkg, the h2ps2 channel interfaces and the block's RTL.
`default_nettype none

module tb_top;

   localparam int FIFO_DEPTH   = h2ps2_pkg::DEFAULT_FIFO_DEPTH;
   localparam int RANDOM_WORDS = 1325;
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side
   localparam int LONG_HOLD    = 300;   // one long back-pressure stretch on responses
   localparam int HOLD_AFTER   = 400;   // responses seen before that stretch starts
   localparam int MAX_PRINTED  = 30;

   typedef enum logic {ACT_KEY = 1'b0, ACT_POP = 1'b1} action_type;
   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   typedef struct packed {
      logic [7:0] scan_byte;
      logic       queue_empty;
      logic [1:0] bytes_queued;
      logic       dropped;
   } scan_rsp_type;

   // one request word; pinned rows carry their own expected response
   typedef struct packed {
      action_type   action;
      logic [7:0]   usage;
      logic         pressed;
      logic         pinned;
      scan_rsp_type want;
   } key_word_type;

   logic clock = 1'b0;
   logic reset;

   h2ps2_req_if req_chan ();
   h2ps2_rsp_if rsp_chan ();

   hid_to_ps2_set2_scan_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: own set 2 map, a byte queue standing in for the FIFO
   // ---------------------------------------------------------------------
   logic [8:0]    set2_map [256];      // bit 8 = E0 prefix, 7..0 = make code
   logic [7:0]    mapped_usages [$];
   logic [7:0]    queued_scan_bytes [$];
   scan_rsp_type  awaited_rsps [$];

   // drives alongside the request payload so the monitor sees the row's pin
   logic          req_pinned;
   scan_rsp_type  req_want;

   int mismatches, words_sent, rsp_seen, idle_gap, stall_cycles;
   int key_words, cut_short, pop_words, empty_pops, deepest_fill;
   bit long_hold_done;

   // returns 1 when the byte landed, 0 when the queue was full
   function automatic int push_scan(input logic [7:0] b);
      if (queued_scan_bytes.size() >= FIFO_DEPTH) return 0;
      queued_scan_bytes.push_back(b);
      return 1;
   endfunction

   function automatic scan_rsp_type predict_scan(input logic act, input logic [7:0] usage,
                                                 input logic down);
      scan_rsp_type r;
      logic [8:0]   entry;
      int           tried, landed;
      r = '0;
      if (act == ACT_POP) begin
         // pop ignores usage and the pressed flag
         if (queued_scan_bytes.size() == 0) r.queue_empty = 1'b1;
         else r.scan_byte = queued_scan_bytes.pop_front();
      end else begin
         entry = set2_map[usage];
         if (entry[7:0] != 8'h00) begin
            tried  = 0;
            landed = 0;
            if (entry[8]) begin
               tried++;
               landed += push_scan(h2ps2_pkg::PFX_EXT);
            end
            if (!down) begin
               tried++;
               landed += push_scan(h2ps2_pkg::PFX_BRK);
            end
            tried++;
            landed += push_scan(entry[7:0]);
            r.bytes_queued = landed[1:0];
            r.dropped      = (landed < tried);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch at response %0d: %s got 0x%0h want 0x%0h",
                  rsp_seen, what, got, want);
   endtask

   function automatic bit quiet_stretch(input int n);
      return ((n / 60) % 4) == 3;
   endfunction

   function automatic key_word_type stim_row(input action_type act, input logic [7:0] usage,
                                             input logic down, input logic pin,
                                             input logic [7:0] byt, input logic emp,
                                             input logic [1:0] queued, input logic lost);
      key_word_type w;
      w.action  = act;
      w.usage   = usage;
      w.pressed = down;
      w.pinned  = pin;
      w.want    = '{scan_byte: byt, queue_empty: emp, bytes_queued: queued, dropped: lost};
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: predicts on request accept, checks on response accept,
   // and ends the run when nothing moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      scan_rsp_type pred, got, want;
      bit           req_fire, rsp_fire;
      req_fire = req_chan.valid && req_chan.ready;
      rsp_fire = rsp_chan.valid && rsp_chan.ready;
      if (!reset) begin
         if (req_fire) begin
            pred = predict_scan(req_chan.action, req_chan.usage_id, req_chan.pressed);
            awaited_rsps.push_back(req_pinned ? req_want : pred);
            if (req_chan.action == ACT_POP) begin
               pop_words++;
               if (pred.queue_empty) empty_pops++;
            end else begin
               key_words++;
               if (pred.dropped) cut_short++;
            end
            if (queued_scan_bytes.size() > deepest_fill) deepest_fill = queued_scan_bytes.size();
         end
         if (rsp_fire) begin
            got = '{scan_byte: rsp_chan.scan_byte, queue_empty: rsp_chan.queue_empty,
                    bytes_queued: rsp_chan.bytes_queued, dropped: rsp_chan.dropped};
            if (awaited_rsps.size() == 0) begin
               report_mismatch("response with nothing awaited", got, 0);
            end else begin
               want = awaited_rsps.pop_front();
               if (got.scan_byte !== want.scan_byte)
                  report_mismatch("scan_byte", got.scan_byte, want.scan_byte);
               if (got.queue_empty !== want.queue_empty)
                  report_mismatch("queue_empty", got.queue_empty, want.queue_empty);
               if (got.bytes_queued !== want.bytes_queued)
                  report_mismatch("bytes_queued", got.bytes_queued, want.bytes_queued);
               if (got.dropped !== want.dropped)
                  report_mismatch("dropped", got.dropped, want.dropped);
            end
            rsp_seen++;
         end
         if (req_fire || rsp_fire) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random ready gaps, quiet stretches, one long hold
   // while the sender keeps offering so the request side backs up
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!long_hold_done && rsp_seen >= HOLD_AFTER) begin
            gap            = LONG_HOLD;
            long_hold_done = 1'b1;
         end else begin
            gap = quiet_stretch(rsp_seen) ? 0 : $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // valid only drops when a gap follows, so back-to-back words keep it high
   task automatic send_word(input key_word_type w);
      if (idle_gap > 0) repeat (idle_gap) @(posedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.action   <= w.action;
      req_chan.usage_id <= w.usage;
      req_chan.pressed  <= w.pressed;
      req_pinned        <= w.pinned;
      req_want          <= w.want;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
      idle_gap = quiet_stretch(words_sent) ? 0 : $urandom_range(0, 10);
      if (idle_gap > 0) req_chan.valid <= 1'b0;
   endtask

   // hold off new words until every response has come back
   task automatic pause_until_drained();
      if (idle_gap == 0) req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   key_word_type directed_words [25];

   initial begin
      key_word_type w;
      phase_type    phase;
      int           made, extra, pop_pct;

      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.action   <= ACT_KEY;
      req_chan.usage_id <= 8'h00;
      req_chan.pressed  <= 1'b0;
      req_pinned        <= 1'b0;
      req_want          <= '0;

      set2_map = '{default: 9'h000};
      set2_map['h04] = 'h01C; set2_map['h05] = 'h032; set2_map['h06] = 'h021;
      set2_map['h07] = 'h023; set2_map['h08] = 'h024; set2_map['h09] = 'h02B;
      set2_map['h0A] = 'h034; set2_map['h0B] = 'h033; set2_map['h0C] = 'h043;
      set2_map['h0D] = 'h03B; set2_map['h0E] = 'h042; set2_map['h0F] = 'h04B;
      set2_map['h10] = 'h03A; set2_map['h11] = 'h031; set2_map['h12] = 'h044;
      set2_map['h13] = 'h04D; set2_map['h14] = 'h015; set2_map['h15] = 'h02D;
      set2_map['h16] = 'h01B; set2_map['h17] = 'h02C; set2_map['h18] = 'h03C;
      set2_map['h19] = 'h02A; set2_map['h1A] = 'h01D; set2_map['h1B] = 'h022;
      set2_map['h1C] = 'h035; set2_map['h1D] = 'h01A; set2_map['h1E] = 'h016;
      set2_map['h1F] = 'h01E; set2_map['h20] = 'h026; set2_map['h21] = 'h025;
      set2_map['h22] = 'h02E; set2_map['h23] = 'h036; set2_map['h24] = 'h03D;
      set2_map['h25] = 'h03E; set2_map['h26] = 'h046; set2_map['h27] = 'h045;
      set2_map['h28] = 'h05A; set2_map['h29] = 'h076; set2_map['h2A] = 'h066;
      set2_map['h2B] = 'h00D; set2_map['h2C] = 'h029; set2_map['h2D] = 'h04E;
      set2_map['h2E] = 'h055; set2_map['h2F] = 'h054; set2_map['h30] = 'h05B;
      set2_map['h31] = 'h05D; set2_map['h32] = 'h05D; set2_map['h33] = 'h04C;
      set2_map['h34] = 'h052; set2_map['h35] = 'h00E; set2_map['h36] = 'h041;
      set2_map['h37] = 'h049; set2_map['h38] = 'h04A; set2_map['h39] = 'h058;
      set2_map['h3A] = 'h005; set2_map['h3B] = 'h006; set2_map['h3C] = 'h004;
      set2_map['h3D] = 'h00C; set2_map['h3E] = 'h003; set2_map['h3F] = 'h00B;
      set2_map['h40] = 'h083; set2_map['h41] = 'h00A; set2_map['h42] = 'h001;
      set2_map['h43] = 'h009; set2_map['h44] = 'h078; set2_map['h45] = 'h007;
      set2_map['h47] = 'h07E;
      // navigation cluster and arrows are extended
      set2_map['h49] = 'h170; set2_map['h4A] = 'h16C; set2_map['h4B] = 'h17D;
      set2_map['h4C] = 'h171; set2_map['h4D] = 'h169; set2_map['h4E] = 'h17A;
      set2_map['h4F] = 'h174; set2_map['h50] = 'h16B; set2_map['h51] = 'h172;
      set2_map['h52] = 'h175; set2_map['h53] = 'h077; set2_map['h54] = 'h14A;
      set2_map['h55] = 'h07C; set2_map['h56] = 'h07B; set2_map['h57] = 'h079;
      set2_map['h58] = 'h15A; set2_map['h59] = 'h069; set2_map['h5A] = 'h072;
      set2_map['h5B] = 'h07A; set2_map['h5C] = 'h06B; set2_map['h5D] = 'h073;
      set2_map['h5E] = 'h074; set2_map['h5F] = 'h06C; set2_map['h60] = 'h075;
      set2_map['h61] = 'h07D; set2_map['h62] = 'h070; set2_map['h63] = 'h071;
      set2_map['h64] = 'h061; set2_map['h65] = 'h12F;
      // modifiers
      set2_map['hE0] = 'h014; set2_map['hE1] = 'h012; set2_map['hE2] = 'h011;
      set2_map['hE3] = 'h11F; set2_map['hE4] = 'h114; set2_map['hE5] = 'h059;
      set2_map['hE6] = 'h111; set2_map['hE7] = 'h127;
      for (int u = 0; u < 256; u++)
         if (set2_map[u][7:0] != 8'h00) mapped_usages.push_back(u[7:0]);

      // Directed words. Pinned rows carry the response by hand; the rest go
      // through the predictor.
      directed_words = '{
         // pop right after reset: empty
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h00,  1'b1, 2'd0, 1'b0),
         // unmapped usages at both ends of the range
         stim_row(ACT_KEY, 8'h00, 1'b1, 1'b1, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'hFF, 1'b0, 1'b1, 8'h00,  1'b0, 2'd0, 1'b0),
         // plain key make and break
         stim_row(ACT_KEY, 8'h04, 1'b1, 1'b1, 8'h00,  1'b0, 2'd1, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h1C,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'h04, 1'b0, 1'b1, 8'h00,  1'b0, 2'd2, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, h2ps2_pkg::PFX_BRK, 1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h1C,  1'b0, 2'd0, 1'b0),
         // extended key make and break
         stim_row(ACT_KEY, 8'h49, 1'b1, 1'b1, 8'h00,  1'b0, 2'd2, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, h2ps2_pkg::PFX_EXT, 1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h70,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'h49, 1'b0, 1'b1, 8'h00,  1'b0, 2'd3, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, h2ps2_pkg::PFX_EXT, 1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, h2ps2_pkg::PFX_BRK, 1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h70,  1'b0, 2'd0, 1'b0),
         // make code with the top bit set
         stim_row(ACT_KEY, 8'h40, 1'b1, 1'b1, 8'h00,  1'b0, 2'd1, 1'b0),
         stim_row(ACT_POP, 8'h00, 1'b0, 1'b1, 8'h83,  1'b0, 2'd0, 1'b0),
         // empty again; pop with junk in the unused fields
         stim_row(ACT_POP, 8'hFF, 1'b1, 1'b1, 8'h00,  1'b1, 2'd0, 1'b0),
         // last mapped usage, hole in the map, application key, past the end, left control, two pops
         stim_row(ACT_KEY, 8'hE7, 1'b0, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'h46, 1'b1, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'h65, 1'b1, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'hE8, 1'b0, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_KEY, 8'hE0, 1'b1, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'h5A, 1'b0, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0),
         stim_row(ACT_POP, 8'hA5, 1'b1, 1'b0, 8'h00,  1'b0, 2'd0, 1'b0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_gap = 0;
      foreach (directed_words[i]) send_word(directed_words[i]);

      // Random part cycles through three phases:
      //   fill  - mostly key events until the FIFO is full, then keep
      //           pushing so sequences get cut short
      //   drain - mostly pops until empty, then a few empty pops
      //   mix   - even split, keeps the pointers wandering past the wrap
      phase = PH_FILL;
      made  = 0;
      extra = 0;
      while (made < RANDOM_WORDS) begin
         case (phase)
            PH_FILL:  pop_pct = 10;
            PH_DRAIN: pop_pct = 90;
            default:  pop_pct = 50;
         endcase
         w          = '0;
         w.action   = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_KEY;
         if (w.action == ACT_KEY && $urandom_range(0, 99) < 85)
            w.usage = mapped_usages[$urandom_range(0, mapped_usages.size() - 1)];
         else
            w.usage = 8'($urandom_range(0, 255));
         w.pressed = 1'($urandom_range(0, 1));
         send_word(w);
         made++;
         case (phase)
            PH_FILL: begin
               if (queued_scan_bytes.size() >= FIFO_DEPTH) extra++;
               if (extra == 24) begin
                  extra = 0;
                  phase = PH_DRAIN;
                  pause_until_drained();
               end
            end
            PH_DRAIN: begin
               if (queued_scan_bytes.size() == 0) extra++;
               if (extra == 12) begin
                  extra = 0;
                  phase = PH_MIX;
               end
            end
            default: begin
               extra++;
               if (extra == 120) begin
                  extra = 0;
                  phase = PH_FILL;
               end
            end
         endcase
      end

      pause_until_drained();
      // leave room for a stray response
      repeat (24) @(posedge clock);
      if (awaited_rsps.size() != 0)
         report_mismatch("responses never seen", awaited_rsps.size(), 0);

      $display("ran %0d words: %0d key events (%0d cut short by a full FIFO),",
               words_sent, key_words, cut_short);
      $display("%0d pops (%0d empty), deepest fill %0d of %0d bytes, %0d mismatches",
               pop_words, empty_pops, deepest_fill, FIFO_DEPTH, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/h2ps2_pkg.sv
rtl/h2ps2_chan_if.sv
rtl/h2ps2_datapath.sv
rtl/h2ps2_ctrl.sv
rtl/hid_to_ps2_set2_scan_fifo.sv
bench/tb_top.sv
